>>> src/iirdf1_pkg.sv
`default_nettype none

package iirdf1_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 20;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + 4;      // 7 products, plus headroom
    localparam int FRAC_W    = 16;               // Q4.16 coefficients

    // Coefficient register file
    localparam int NUM_REGS  = 7;
    localparam int REG_IDX_W = 3;
    localparam int DEPTH     = 3;
    localparam int TAP_W     = 2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_FF_COEF_0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FB_BASE   = 3'd3;   // fb_coef_k sits at 3 + k

    localparam logic signed [COEF_W-1:0] FF_COEF_0_RESET = 20'sd65536;
    localparam logic signed [ACC_W-1:0]  RND_BIAS        = 40'sd32768;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    // Controller -> datapath
    typedef struct packed {
        logic             load;     // capture new word, start tap 0 product
        logic             mul_en;   // form product of the selected tap
        logic             acc_en;   // add/subtract last product
        logic             sel_fb;   // selected tap is a feedback tap
        logic [TAP_W-1:0] tap;      // tap number, 1..3
        logic             fin;      // round, saturate, shift delay lines
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;             // output register can take a result now
    } t_status;

endpackage

`default_nettype wire

>>> src/iir_filter_direct_form_one_unit.sv
// Direct-form-I IIR filter, one shared 20x16 multiplier and a 40-bit accumulator.
// Sequence: tap 0 multiplies on the accept cycle, then come the remaining feed-forward taps,
//   the feedback taps, a drain step and a finish step that waits while the output register is full.
// A new word is accepted on the finish cycle of the previous one, as its result is registered.
// Reset (synchronous, active low): ff_coef_0 = 1.0, other coefficients 0, delay lines zero.
`default_nettype none

module iir_filter_direct_form_one_unit #(
    parameter int FF_TAPS = 4,
    parameter int FB_TAPS = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_wr_en,
    input  logic [iirdf1_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [iirdf1_pkg::COEF_W-1:0]          i_cfg_data,
    // input words
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] i_sample_in,
    // output words
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                   o_clipped
);
    import iirdf1_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Controller walks the taps: tap 0 multiplies on the accept cycle, then
    // feed-forward taps 1..FF_TAPS-1 and feedback taps 1..FB_TAPS-1, one per cycle.
    iirdf1_ctrl #(
        .FF_TAPS (FF_TAPS),
        .FB_TAPS (FB_TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: coefficient registers, delay lines, registered product,
    // accumulator, round/saturate and the output register.
    iirdf1_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

endmodule

`default_nettype wire

>>> src/iirdf1_ctrl.sv
`default_nettype none

module iirdf1_ctrl #(
    parameter int FF_TAPS = 4,
    parameter int FB_TAPS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  iirdf1_pkg::t_status  i_status,
    output iirdf1_pkg::t_cmd     o_cmd
);
    import iirdf1_pkg::*;

    localparam int NUM_STEPS = FF_TAPS + FB_TAPS - 1;
    localparam int STEP_W    = $clog2(NUM_STEPS + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);
    localparam logic [STEP_W-1:0] FF_END    = STEP_W'(FF_TAPS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;
    logic              accept;
    logic [1:0]        start_state;

    // with a single tap there is nothing to multiply after tap 0
    assign start_state = (NUM_STEPS > 1) ? ST_MUL : ST_DRAIN;

    assign o_in_ready = (r_state == ST_IDLE) ||
                        ((r_state == ST_FIN) && i_status.out_free);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.load = accept;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = start_state;
                    n_step  = STEP_W'(1);
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.acc_en = 1'b1;
                if (r_step < FF_END) begin
                    o_cmd.sel_fb = 1'b0;
                    o_cmd.tap    = TAP_W'(r_step);
                end else begin
                    o_cmd.sel_fb = 1'b1;
                    o_cmd.tap    = TAP_W'(r_step + STEP_W'(1) - FF_END);
                end
                if (r_step == LAST_STEP) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_DRAIN: begin
                o_cmd.acc_en = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    if (accept) begin
                        n_state = start_state;
                        n_step  = STEP_W'(1);
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_MUL || r_state == ST_DRAIN))
        else $error("accepted word did not start the tap sequence");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_step != '0 && r_step <= LAST_STEP))
        else $error("tap step out of range");

    a_drain_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |=> (r_state == ST_FIN))
        else $error("drain did not lead to finish");

endmodule

`default_nettype wire

>>> src/iirdf1_dp.sv
`default_nettype none

module iirdf1_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [iirdf1_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [iirdf1_pkg::COEF_W-1:0]         i_cfg_data,
    input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] i_sample_in,
    input  iirdf1_pkg::t_cmd                      i_cmd,
    output iirdf1_pkg::t_status                   o_status,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                  o_clipped
);
    import iirdf1_pkg::*;

    localparam int RND_W = ACC_W - FRAC_W;

    t_coef   r_coef     [NUM_REGS];
    t_sample r_past_in  [DEPTH];
    t_sample r_past_out [DEPTH];
    t_sample r_x;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_sub;
    logic signed [ACC_W-1:0]  r_acc;

    logic    r_out_valid;
    t_sample r_sample_out;
    logic    r_clipped;

    logic [REG_IDX_W-1:0]    coef_idx;
    t_coef                   coef_sel;
    t_sample                 samp_sel;
    t_coef                   mul_a;
    t_sample                 mul_b;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] rnd_sum;
    logic [RND_W-1:0]        rnd;
    logic [RND_W-SAMPLE_W:0] rnd_top;
    logic                    ovf;
    t_sample                 sat_val;

    // tap operand select
    assign coef_idx = (i_cmd.sel_fb ? REG_FB_BASE : REG_FF_COEF_0) +
                      REG_IDX_W'(i_cmd.tap);
    assign coef_sel = r_coef[coef_idx];

    always_comb begin
        case (i_cmd.tap)
            2'd1:    samp_sel = i_cmd.sel_fb ? r_past_out[0] : r_past_in[0];
            2'd2:    samp_sel = i_cmd.sel_fb ? r_past_out[1] : r_past_in[1];
            2'd3:    samp_sel = i_cmd.sel_fb ? r_past_out[2] : r_past_in[2];
            default: samp_sel = r_x;
        endcase
    end

    // tap 0 is taken straight from the port on the accept cycle
    assign mul_a = i_cmd.load ? r_coef[REG_FF_COEF_0] : coef_sel;
    assign mul_b = i_cmd.load ? i_sample_in           : samp_sel;

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // round half up, then saturate
    assign rnd_sum = r_acc + RND_BIAS;
    assign rnd     = rnd_sum[ACC_W-1:FRAC_W];
    assign rnd_top = rnd[RND_W-1:SAMPLE_W-1];
    assign ovf     = !((&rnd_top) || !(|rnd_top));
    assign sat_val = ovf ? (rnd[RND_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                         : t_sample'(rnd[SAMPLE_W-1:0]);

    assign o_status.out_free = !r_out_valid || i_out_ready;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= (i == int'(REG_FF_COEF_0)) ? FF_COEF_0_RESET : '0;
            end
        end else if (i_cfg_wr_en && (i_cfg_index < REG_IDX_W'(NUM_REGS))) begin
            r_coef[i_cfg_index] <= t_coef'(i_cfg_data);
        end
    end

    // delay lines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_past_in[i]  <= '0;
                r_past_out[i] <= '0;
            end
        end else if (i_cmd.fin) begin
            for (int i = DEPTH - 1; i > 0; i--) begin
                r_past_in[i]  <= r_past_in[i-1];
                r_past_out[i] <= r_past_out[i-1];
            end
            r_past_in[0]  <= r_x;
            r_past_out[0] <= sat_val;
        end
    end

    // multiply-accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.load || i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
            r_sub  <= i_cmd.load ? 1'b0 : i_cmd.sel_fb;
        end
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_sub ? (r_acc - prod_ext) : (r_acc + prod_ext);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_sample_out <= sat_val;
            r_clipped    <= ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

endmodule

`default_nettype wire
